// ----- rtl/mpcp_pkg.sv -----
// Shared types and constants for the MP configuration table CPU parser.
// No dependencies; imported by every module of the block.
package mpcp_pkg;

  // Table header layout
  localparam int unsigned HEADER_BYTES = 44;
  localparam logic [5:0]  HDR_LAST     = 6'(HEADER_BYTES - 1);
  localparam logic [5:0]  CNT_LO_OFF   = 6'd34;
  localparam logic [5:0]  CNT_HI_OFF   = 6'd35;

  // Entry types and lengths (last byte offset within an entry)
  localparam logic [2:0]  ENT_PROC     = 3'd0;
  localparam logic [7:0]  ENT_TYPE_MAX = 8'd4;
  localparam logic [5:0]  PROC_LAST    = 6'd19;
  localparam logic [5:0]  SHORT_LAST   = 6'd7;
  localparam logic [5:0]  PROC_ID_OFF  = 6'd1;
  localparam logic [5:0]  PROC_FLG_OFF = 6'd3;

  // Processor flags byte
  localparam int unsigned FLAG_EN_BIT   = 0;
  localparam int unsigned FLAG_BOOT_BIT = 1;

  // Input commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_FIN = 2'd0;
  localparam logic [1:0] KIND_INV = 2'd1;
  localparam logic [1:0] KIND_RD  = 2'd2;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic       first;
    logic [3:0] read_index;
  } mpcp_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] cpu_count;
    logic [3:0] bsp_index;
    logic       bsp_found;
    logic       overflow;
    logic [7:0] apic_id;
  } mpcp_out_t;

endpackage

// ----- rtl/mpcp_core.sv -----
// Parse state and per-beat logic: header offset count, entry walk, CPU ID list.
// Depends on mpcp_pkg. Updates state on each fired beat and flags a result.
module mpcp_core import mpcp_pkg::*; #(
  parameter int unsigned MAX_CPUS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  mpcp_in_t  beat_i,
  output logic      res_valid_o,
  output mpcp_out_t res_o
);

  localparam int unsigned CntW = $clog2(MAX_CPUS + 1);
  localparam int unsigned IdxW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_ENT  = 2'd2;

  logic [1:0]      phase_q, phase_d;
  logic [5:0]      off_q, off_d;
  logic [15:0]     exp_q, exp_d;
  logic [15:0]     done_q, done_d;
  logic [2:0]      ekind_q, ekind_d;
  logic [7:0]      pid_q, pid_d;
  logic [CntW-1:0] total_q, total_d;
  logic [IdxW-1:0] bsp_q, bsp_d;
  logic            seen_q, seen_d;
  logic            ovf_q, ovf_d;
  logic [7:0]      list_q [MAX_CPUS];

  // effective state after an optional restart by first
  logic            clr;
  logic [1:0]      cur_phase;
  logic [5:0]      cur_off;
  logic [15:0]     cur_exp;
  logic [15:0]     cur_done;
  logic [2:0]      cur_ekind;
  logic [CntW-1:0] cur_total;
  logic            is_proc;
  logic [5:0]      last_off;
  logic            list_we;
  logic [1:0]      res_kind;
  logic [7:0]      b;
  logic            rd_hit;
  logic [7:0]      rd_id;

  assign b   = beat_i.data_byte;
  assign clr = fire_i && (beat_i.command == CMD_BYTE) && beat_i.first;

  always_comb begin
    cur_phase = clr ? PH_HDR : phase_q;
    cur_off   = clr ? 6'd0 : off_q;
    cur_exp   = clr ? 16'd0 : exp_q;
    cur_done  = clr ? 16'd0 : done_q;
    cur_ekind = clr ? 3'd0 : ekind_q;
    cur_total = clr ? '0 : total_q;
  end

  assign is_proc  = (cur_ekind == ENT_PROC);
  assign last_off = is_proc ? PROC_LAST : SHORT_LAST;

  always_comb begin
    phase_d     = cur_phase;
    off_d       = cur_off;
    exp_d       = cur_exp;
    done_d      = cur_done;
    ekind_d     = cur_ekind;
    pid_d       = clr ? 8'd0 : pid_q;
    total_d     = cur_total;
    bsp_d       = clr ? '0 : bsp_q;
    seen_d      = clr ? 1'b0 : seen_q;
    ovf_d       = clr ? 1'b0 : ovf_q;
    list_we     = 1'b0;
    res_valid_o = 1'b0;
    res_kind    = KIND_FIN;

    if (fire_i && beat_i.command == CMD_READ) begin
      res_valid_o = 1'b1;
      res_kind    = KIND_RD;
      phase_d     = phase_q;
    end else if (fire_i) begin
      unique case (cur_phase)
        PH_HDR: begin
          if (cur_off == CNT_LO_OFF) begin
            exp_d = {8'h00, b};
          end else if (cur_off == CNT_HI_OFF) begin
            exp_d = {b, cur_exp[7:0]};
          end
          if (cur_off >= HDR_LAST) begin
            off_d  = 6'd0;
            done_d = 16'd0;
            if (exp_d == 16'd0) begin
              phase_d     = PH_IDLE;
              res_valid_o = 1'b1;
            end else begin
              phase_d = PH_ENT;
            end
          end else begin
            off_d = cur_off + 6'd1;
          end
        end
        PH_ENT: begin
          if (cur_off == 6'd0) begin
            if (b > ENT_TYPE_MAX) begin
              phase_d     = PH_IDLE;
              res_valid_o = 1'b1;
              res_kind    = KIND_INV;
            end else begin
              ekind_d = b[2:0];
              off_d   = 6'd1;
            end
          end else begin
            if (is_proc && cur_off == PROC_ID_OFF) begin
              pid_d = b;
            end
            if (is_proc && cur_off == PROC_FLG_OFF && b[FLAG_EN_BIT]) begin
              if (cur_total >= CntW'(MAX_CPUS)) begin
                ovf_d = 1'b1;
              end else begin
                list_we = 1'b1;
                total_d = cur_total + CntW'(1);
                if (b[FLAG_BOOT_BIT]) begin
                  bsp_d  = IdxW'(cur_total);
                  seen_d = 1'b1;
                end
              end
            end
            if (cur_off >= last_off) begin
              off_d  = 6'd0;
              done_d = cur_done + 16'd1;
              if (done_d == cur_exp) begin
                phase_d     = PH_IDLE;
                res_valid_o = 1'b1;
              end
            end else begin
              off_d = cur_off + 6'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ID read: guarded so the list is never indexed past its fill
  assign rd_hit = ({4'h0, beat_i.read_index} < 8'(total_q)) &&
                  ({4'h0, beat_i.read_index} < 8'(MAX_CPUS));
  assign rd_id  = rd_hit ? list_q[IdxW'(beat_i.read_index)] : 8'h00;

  always_comb begin
    res_o.kind      = res_kind;
    res_o.cpu_count = 5'(total_d);
    res_o.bsp_index = 4'(bsp_d);
    res_o.bsp_found = seen_d;
    res_o.overflow  = ovf_d;
    res_o.apic_id   = (res_kind == KIND_RD) ? rd_id : 8'h00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      off_q   <= '0;
      exp_q   <= '0;
      done_q  <= '0;
      ekind_q <= '0;
      pid_q   <= '0;
      total_q <= '0;
      bsp_q   <= '0;
      seen_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      off_q   <= off_d;
      exp_q   <= exp_d;
      done_q  <= done_d;
      ekind_q <= ekind_d;
      pid_q   <= pid_d;
      total_q <= total_d;
      bsp_q   <= bsp_d;
      seen_q  <= seen_d;
      ovf_q   <= ovf_d;
    end
  end

  // list entries at or above the count are never read, so no clear needed
  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_q[IdxW'(cur_total)] <= pid_q;
    end
  end

endmodule

// ----- rtl/mp_config_table_cpu_parser.sv -----
// MP configuration table CPU parser, top level: input stage, parse core,
// two-entry result buffer. Depends on mpcp_pkg and mpcp_core.
//
// Usage: send the table one byte per input beat (command = 0), with first set
// on header byte 0. The block counts the header, takes the entry count at
// offsets 34/35, walks processor (20 byte) and other (8 byte) entries and
// records enabled processor APIC IDs. At table end one result beat of kind
// "finished" carries count, BSP index and overflow; a bad entry type gives an
// "invalid" beat and stops the parse. A read beat (command = 1) returns the
// recorded ID at read_index, any time, without disturbing a parse.
// Most table bytes give no result beat.
// Throughput: one input beat per cycle while a result slot is free; the parse
// logic is combinational between the input register and the result register.
// A result passes through the input register and then the result register
// before out_valid_o rises.
// Reset clears the parse to idle, the CPU count and both buffers.
// When the receiver stalls, up to two results are held; input keeps flowing
// until the second slot fills, then in_ready_o drops.
module mp_config_table_cpu_parser import mpcp_pkg::*; #(
  parameter int unsigned MAX_CPUS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mpcp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mpcp_out_t out_data_o
);

  logic      in_valid_q;
  mpcp_in_t  in_q;
  logic      adv;
  logic      res_valid;
  mpcp_out_t res;
  logic      out_valid_q, skid_valid_q;
  mpcp_out_t out_q, skid_q;
  logic      pop;

  assign adv        = in_valid_q && !skid_valid_q;
  assign in_ready_o = !in_valid_q || adv;
  assign pop        = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  mpcp_core #(
    .MAX_CPUS(MAX_CPUS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (adv),
    .beat_i     (in_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  logic push;
  assign push = adv && res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= push;
        end else begin
          out_valid_q  <= push;
        end
      end else if (push) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push) begin
          skid_q <= res;
        end
      end else if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      if (out_valid_q) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/mpcp_checker.sv -----
// Port-level checks for the MP configuration table CPU parser, and its bind.
// Depends on mpcp_pkg; attaches to mp_config_table_cpu_parser.
module mpcp_checker import mpcp_pkg::*; #(
  parameter int unsigned MAX_CPUS = 16
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input mpcp_out_t out_data_o
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // reset takes hold by the next edge at the latest
  a_rst_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_RD |-> out_data_o.apic_id == 8'h00)
    else $error("nonzero apic_id on finished/invalid result");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow && (MAX_CPUS < 32)
    |-> out_data_o.cpu_count == 5'(MAX_CPUS))
    else $error("overflow with CPU list not full");

  a_bsp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bsp_found && (MAX_CPUS <= 16)
    |-> {1'b0, out_data_o.bsp_index} < out_data_o.cpu_count)
    else $error("BSP index beyond CPU count");

endmodule

bind mp_config_table_cpu_parser mpcp_checker #(
  .MAX_CPUS(MAX_CPUS)
) u_mpcp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
